FILE: hdl/ihex_pkg.sv
package ihex_pkg;

	// record and image geometry
	localparam int MAX_DATA       = 16;
	localparam int IMAGE_BYTES    = 1048576;
	localparam int BLOCK_BYTES    = 65536;
	localparam int MIN_LINE_CHARS = 11;
	localparam int HDR_BYTES      = 4;

	// block size is a power of two, so alignment is a mask test
	localparam logic [31:0] BLOCK_MASK = 32'(BLOCK_BYTES - 1);

	localparam int DATA_AW     = $clog2(MAX_DATA);
	localparam int CNT_W       = $clog2(MAX_DATA + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int BANK_W      = QPTR_W;
	localparam int RAM_AW      = BANK_W + DATA_AW;
	localparam int RAM_DEPTH   = 1 << RAM_AW;
	localparam int OFF_W       = 20;
	localparam int IDX_W       = 10;
	localparam logic [IDX_W-1:0] IDX_MAX = '1;

	// request kinds
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_CHAR  = 1'b1;

	// register indexes
	localparam logic REG_BASE = 1'b0;
	localparam logic REG_LEN  = 1'b1;

	// status codes
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_NOT_STARTED  = 3'd1;
	localparam logic [2:0] ST_BAD_RECORD   = 3'd2;
	localparam logic [2:0] ST_LENGTH       = 3'd3;
	localparam logic [2:0] ST_MISALIGNED   = 3'd4;
	localparam logic [2:0] ST_OUT_OF_IMAGE = 3'd5;

	// record types and characters
	localparam logic [7:0] KIND_DATA = 8'h00;
	localparam logic [7:0] KIND_EOF  = 8'h01;
	localparam logic [7:0] KIND_PAGE = 8'h04;
	localparam logic [7:0] CHAR_COLON = 8'h3A;

	// one classified line or start, waiting for the back end
	typedef struct packed {
		logic [2:0]        status;
		logic [CNT_W-1:0]  nwr;
		logic [OFF_W-1:0]  offset;
		logic [BANK_W-1:0] bank;
	} q_entry_t;

	// data byte store write port
	typedef struct packed {
		logic              we;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	// hex digit decode: {valid, nibble}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c inside {[8'h41:8'h46]}) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c inside {[8'h61:8'h66]}) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

FILE: hdl/ihex_ram.sv
module ihex_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/ihex_front.sv
module ihex_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [7:0]          char_code,
	input  logic                end_of_line,
	output logic                push,
	output ihex_pkg::q_entry_t  push_entry,
	input  logic                q_full,
	output ihex_pkg::ram_wr_t   ram_wr
);

	logic [31:0] base_q;
	logic [20:0] len_q;
	logic [32:0] lim_q;

	logic        armed_q;
	logic [31:0] exp_q;
	logic [15:0] page_q;

	logic [ihex_pkg::IDX_W-1:0]  idx_q;
	logic [3:0]  hi_q;
	logic [7:0]  sum_q;
	logic [7:0]  cnt_q;
	logic [15:0] ladr_q;
	logic [7:0]  kind_q;
	logic        bad_q;
	logic [7:0]  d0_q;
	logic [7:0]  d1_q;
	logic        fsh_q;
	logic [ihex_pkg::BANK_W-1:0] bank_q;

	logic        acc;
	logic        acc_start;
	logic        acc_char;
	logic [4:0]  hv;
	logic [7:0]  byte_v;
	logic [8:0]  k;
	logic [8:0]  kd;
	logic        byte_done;
	logic        in_slot;

	logic [2:0]  s_status;
	logic [9:0]  len_need;
	logic        rec_bad;
	logic [31:0] addr;
	logic [32:0] end_a;
	logic [2:0]  f_status;
	logic [ihex_pkg::CNT_W-1:0] f_nwr;
	logic        set_exp;
	logic        set_page;

	// handshake: no character is taken in the finish cycle that closes each line, and a free bank is needed
	assign in_ready  = !fsh_q && !q_full;
	assign acc       = in_valid && in_ready;
	assign acc_start = acc && (req_type == ihex_pkg::REQ_START);
	assign acc_char  = acc && (req_type == ihex_pkg::REQ_CHAR);

	// character decode
	assign hv        = ihex_pkg::hex_value(char_code);
	assign byte_v    = {hi_q, hv[3:0]};
	assign k         = idx_q[ihex_pkg::IDX_W-1:1] - 9'd1;
	assign kd        = k - 9'(ihex_pkg::HDR_BYTES);
	assign byte_done = (idx_q != '0) && !idx_q[0];
	assign in_slot   = (k >= 9'(ihex_pkg::HDR_BYTES)) &&
		(k < 9'(ihex_pkg::HDR_BYTES + ihex_pkg::MAX_DATA));

	// data bytes go to the bank of the line being assembled
	assign ram_wr.we   = acc_char && byte_done && in_slot;
	assign ram_wr.addr = {bank_q, kd[ihex_pkg::DATA_AW-1:0]};
	assign ram_wr.data = byte_v;

	// start checks
	always_comb begin
		if (len_q == '0 || 32'(len_q) > 32'(ihex_pkg::IMAGE_BYTES)) begin
			s_status = ihex_pkg::ST_LENGTH;
		end else if ((base_q & ihex_pkg::BLOCK_MASK) != '0) begin
			s_status = ihex_pkg::ST_MISALIGNED;
		end else begin
			s_status = ihex_pkg::ST_OK;
		end
	end

	// end of line classification
	assign len_need = 10'({cnt_q, 1'b0}) + 10'(ihex_pkg::MIN_LINE_CHARS);
	assign rec_bad  = bad_q || (idx_q != len_need) || (sum_q != '0) ||
		(cnt_q > 8'(ihex_pkg::MAX_DATA));
	assign addr     = {page_q, ladr_q};
	assign end_a    = {1'b0, addr} + 33'(cnt_q);

	always_comb begin
		f_status = ihex_pkg::ST_OK;
		f_nwr    = '0;
		set_exp  = 1'b0;
		set_page = 1'b0;
		if (!armed_q) begin
			f_status = ihex_pkg::ST_NOT_STARTED;
		end else if (rec_bad) begin
			f_status = ihex_pkg::ST_BAD_RECORD;
		end else begin
			case (kind_q)
				ihex_pkg::KIND_DATA: begin
					if (addr < exp_q) begin
						f_status = ihex_pkg::ST_BAD_RECORD;
					end else if (addr < base_q || end_a > lim_q) begin
						f_status = ihex_pkg::ST_OUT_OF_IMAGE;
					end else begin
						f_nwr   = cnt_q[ihex_pkg::CNT_W-1:0];
						set_exp = 1'b1;
					end
				end
				ihex_pkg::KIND_PAGE: begin
					if (cnt_q != 8'd2) begin
						f_status = ihex_pkg::ST_BAD_RECORD;
					end else begin
						set_page = 1'b1;
					end
				end
				ihex_pkg::KIND_EOF: begin
					f_status = ihex_pkg::ST_OK;
				end
				default: begin
					f_status = ihex_pkg::ST_BAD_RECORD;
				end
			endcase
		end
	end

	// queue request
	assign push = acc_start || fsh_q;
	always_comb begin
		push_entry.bank = bank_q;
		if (fsh_q) begin
			push_entry.status = f_status;
			push_entry.nwr    = f_nwr;
			push_entry.offset = addr[ihex_pkg::OFF_W-1:0] - base_q[ihex_pkg::OFF_W-1:0];
		end else begin
			push_entry.status = s_status;
			push_entry.nwr    = '0;
			push_entry.offset = '0;
		end
	end

	// configuration registers and image limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			len_q  <= '0;
			lim_q  <= '0;
		end else begin
			lim_q <= {1'b0, base_q} + 33'(len_q);
			if (cfg_we) begin
				case (cfg_index)
					ihex_pkg::REG_BASE: base_q <= cfg_data;
					ihex_pkg::REG_LEN:  len_q  <= cfg_data[20:0];
					default: ;
				endcase
			end
		end
	end

	// session and line assembly state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			exp_q   <= '0;
			page_q  <= '0;
			idx_q   <= '0;
			hi_q    <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
			ladr_q  <= '0;
			kind_q  <= '0;
			bad_q   <= 1'b0;
			d0_q    <= '0;
			d1_q    <= '0;
			fsh_q   <= 1'b0;
			bank_q  <= '0;
		end else begin
			if (push) begin
				bank_q <= bank_q + 1'b1;
			end
			if (acc_start || fsh_q) begin
				idx_q  <= '0;
				hi_q   <= '0;
				sum_q  <= '0;
				cnt_q  <= '0;
				ladr_q <= '0;
				kind_q <= '0;
				bad_q  <= 1'b0;
			end
			if (acc_start) begin
				armed_q <= (s_status == ihex_pkg::ST_OK);
				if (s_status == ihex_pkg::ST_OK) begin
					exp_q <= base_q;
				end
			end
			if (fsh_q) begin
				fsh_q <= 1'b0;
				if (set_exp) begin
					exp_q <= end_a[31:0];
				end
				if (set_page) begin
					page_q <= {d0_q, d1_q};
				end
			end
			if (acc_char) begin
				if (idx_q == '0) begin
					if (char_code != ihex_pkg::CHAR_COLON) begin
						bad_q <= 1'b1;
					end
				end else begin
					if (!hv[4]) begin
						bad_q <= 1'b1;
					end
					if (idx_q[0]) begin
						hi_q <= hv[3:0];
					end else begin
						sum_q <= sum_q + byte_v;
						case (k)
							9'd0: cnt_q <= byte_v;
							9'd1: ladr_q[15:8] <= byte_v;
							9'd2: ladr_q[7:0] <= byte_v;
							9'd3: kind_q <= byte_v;
							9'd4: d0_q <= byte_v;
							9'd5: d1_q <= byte_v;
							default: ;
						endcase
					end
				end
				if (idx_q != ihex_pkg::IDX_MAX) begin
					idx_q <= idx_q + 1'b1;
				end
				if (end_of_line) begin
					fsh_q <= 1'b1;
				end
			end
		end
	end

	// finish cycle always hands one entry on and takes no character
	a_fsh_push: assert property (@(posedge clk) disable iff (!arst_n)
		fsh_q |-> (push && !ram_wr.we && !acc))
		else $error("finish cycle without queue request");

endmodule

FILE: hdl/ihex_queue.sv
module ihex_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ihex_pkg::q_entry_t  push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output ihex_pkg::q_entry_t  head
);

	ihex_pkg::q_entry_t mem_q [ihex_pkg::QUEUE_DEPTH];
	logic [ihex_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [ihex_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [ihex_pkg::QPTR_W:0]   cnt_q;

	assign full       = (cnt_q == (ihex_pkg::QPTR_W + 1)'(ihex_pkg::QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue underflow");

endmodule

FILE: hdl/ihex_back.sv
module ihex_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  ihex_pkg::q_entry_t            head,
	output logic                          pop,
	output logic                          ram_re,
	output logic [ihex_pkg::RAM_AW-1:0]   ram_raddr,
	input  logic [7:0]                    ram_rdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic                          write_valid,
	output logic [19:0]                   write_offset,
	output logic [7:0]                    write_byte,
	output logic                          last
);

	logic [ihex_pkg::CNT_W-1:0] j_q;

	logic                       s1_valid_s1;
	logic                       s1_last_s1;
	logic                       s1_wr_s1;
	logic [ihex_pkg::OFF_W-1:0] s1_off_s1;
	logic [2:0]                 s1_status_s1;

	logic       out_valid_q;
	logic [2:0] status_q;
	logic       wv_q;
	logic [19:0] off_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic out_free;
	logic s1_free;
	logic issue;
	logic issue_wr;
	logic issue_fin;

	// stage flow
	assign out_free  = !out_valid_q || out_ready;
	assign s1_free   = !s1_valid_s1 || out_free;
	assign issue     = head_valid && s1_free;
	assign issue_wr  = issue && (j_q < head.nwr);
	assign issue_fin = issue && !(j_q < head.nwr);

	// entry leaves the queue once its final result is issued
	assign pop       = issue_fin;
	assign ram_re    = issue_wr;
	assign ram_raddr = {head.bank, j_q[ihex_pkg::DATA_AW-1:0]};

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign write_valid  = wv_q;
	assign write_offset = off_q;
	assign write_byte   = byte_q;
	assign last         = last_q;

	// byte counter and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q         <= '0;
			s1_valid_s1 <= 1'b0;
		end else begin
			if (issue_fin) begin
				j_q <= '0;
			end else if (issue_wr) begin
				j_q <= j_q + 1'b1;
			end
			if (issue) begin
				s1_valid_s1 <= 1'b1;
			end else if (out_free) begin
				s1_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_last_s1   <= issue_fin;
			s1_wr_s1     <= issue_wr;
			s1_off_s1    <= head.offset + ihex_pkg::OFF_W'(j_q);
			s1_status_s1 <= issue_fin ? head.status : ihex_pkg::ST_OK;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_s1) begin
			status_q <= s1_status_s1;
			wv_q     <= s1_wr_s1;
			off_q    <= s1_wr_s1 ? s1_off_s1 : '0;
			byte_q   <= s1_wr_s1 ? ram_rdata : '0;
			last_q   <= s1_last_s1;
		end
	end

	a_pop_final: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (s1_valid_s1 && s1_last_s1 && !s1_wr_s1))
		else $error("queue entry released without its final result");

endmodule

FILE: hdl/intel_hex_record_loader.sv
// Intel HEX record loader.
// Input channel (in_valid/in_ready): req_type 0 starts a session with the
// current base_address and image_length; req_type 1 carries one record
// character, end_of_line marking the last one of a line.
// Output channel (out_valid/out_ready): image byte writes (write_valid 1,
// write_offset, write_byte) followed by one result with last 1 and the status.
// Each start and each end of line gives exactly one last result.
// Configuration: cfg_we with cfg_index 0 (base_address) or 1 (image_length);
// the user must write them only while the block is idle (the block has no check).
// Throughput: one character per cycle while the queue has room; the end-of-line
// character is followed by a finish cycle in the parser. The drain side gives
// one result per cycle while out_ready is high; an accepted data line of n bytes
// yields n+1 results. A start result passes the queue entry, the read stage and
// the output register; a line's first result follows its finish cycle likewise.
// A four-entry queue separates parser and drain; outside finish cycles the
// parser stalls only on a full queue; each queued line pins a byte-store bank.
// A stalled receiver backs up the queue; nothing is lost.
// Reset: the session is disarmed, upper page and expected address are zero,
// and both channels are empty.
module intel_hex_record_loader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  char_code,
	input  logic        end_of_line,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        write_valid,
	output logic [19:0] write_offset,
	output logic [7:0]  write_byte,
	output logic        last
);

	logic                          push;
	ihex_pkg::q_entry_t            push_entry;
	logic                          q_full;
	logic                          pop;
	logic                          head_valid;
	ihex_pkg::q_entry_t            head;
	ihex_pkg::ram_wr_t             ram_wr;
	logic                          ram_re;
	logic [ihex_pkg::RAM_AW-1:0]   ram_raddr;
	logic [7:0]                    ram_rdata;

	// parser and classifier
	ihex_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.char_code  (char_code),
		.end_of_line(end_of_line),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full),
		.ram_wr     (ram_wr)
	);

	// line queue
	ihex_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	// data byte store, one bank per queue slot
	ihex_ram #(
		.WIDTH(8),
		.DEPTH(ihex_pkg::RAM_DEPTH)
	) u_bytes (
		.clk  (clk),
		.we   (ram_wr.we),
		.waddr(ram_wr.addr),
		.wdata(ram_wr.data),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// write drain and output register
	ihex_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.write_valid (write_valid),
		.write_offset(write_offset),
		.write_byte  (write_byte),
		.last        (last)
	);

endmodule
